### hw/rtl/rgt_pkg.sv
`timescale 1ns / 1ps

package rgt_pkg;

    // Fixed field widths.
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int PIX_W   = 10;
    localparam int INT_W   = 8;

    // Default largest supported image dimension.
    localparam int MAX_DIM = 1024;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_SHAPE_MODE   = 2'd2;

    // Shape mode codes.
    localparam logic SHAPE_CONE   = 1'b0;
    localparam logic SHAPE_SPHERE = 1'b1;

    // Register values after reset.
    localparam int RESET_WIDTH  = 64;
    localparam int RESET_HEIGHT = 64;

    // Distance and square root sizes.
    localparam int RAD_W   = 16;
    localparam int ROOT_W  = 8;
    localparam int REM_W   = ROOT_W + 3;
    localparam logic [RAD_W-1:0] RAD_MAX = 16'hFFFF;

    // Radius scale: the root is multiplied by 2**SCALE_SH before division.
    localparam int SCALE_SH = 9;

    // Pipelined root and quotient units: bits resolved per stage and stage count.
    localparam int BITS_PER_STG = 2;
    localparam int ROOT_STG     = ROOT_W / BITS_PER_STG;
    localparam int QUOT_STG     = INT_W / BITS_PER_STG;

endpackage

### hw/rtl/rgt_dist.sv
`timescale 1ns / 1ps

// Three-stage squared distance from the texture centre, clamped to 16 bits.
module rgt_dist #(
    parameter int DIM_W = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [rgt_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [rgt_pkg::PIX_W-1:0]     i_pixel_y,
    input  logic [DIM_W-1:0]              i_width,
    input  logic [DIM_W-1:0]              i_height,
    output logic                          o_vld,
    output logic [rgt_pkg::RAD_W-1:0]     o_dist
);

    localparam int AD_W  = (rgt_pkg::PIX_W > DIM_W - 1) ? rgt_pkg::PIX_W : DIM_W - 1;
    localparam int SQ_W  = 2 * AD_W;
    localparam int SUM_W = SQ_W + 1;

    logic [AD_W-1:0]  n_adx, n_ady;
    logic [AD_W-1:0]  r_adx, r_ady;
    logic [AD_W-1:0]  w_px, w_py, w_xc, w_yc;
    logic [SQ_W-1:0]  r_sqx, r_sqy;
    logic [SUM_W-1:0] w_sum;
    logic [rgt_pkg::RAD_W-1:0] r_dist;
    logic             r_vld1, r_vld2, r_vld3;

    assign w_px = AD_W'(i_pixel_x);
    assign w_py = AD_W'(i_pixel_y);
    assign w_xc = AD_W'(i_width  >> 1);
    assign w_yc = AD_W'(i_height >> 1);

    always_comb begin
        n_adx = (w_px >= w_xc) ? (w_px - w_xc) : (w_xc - w_px);
        n_ady = (w_py >= w_yc) ? (w_py - w_yc) : (w_yc - w_py);
    end

    assign w_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adx <= n_adx;
        r_ady <= n_ady;
        r_sqx <= r_adx * r_adx;
        r_sqy <= r_ady * r_ady;
        if (w_sum > SUM_W'(rgt_pkg::RAD_MAX)) begin
            r_dist <= rgt_pkg::RAD_MAX;
        end else begin
            r_dist <= w_sum[rgt_pkg::RAD_W-1:0];
        end
    end

    assign o_vld  = r_vld3;
    assign o_dist = r_dist;

endmodule

### hw/rtl/rgt_sqrt.sv
`timescale 1ns / 1ps

// Pipelined floor square root of a 16-bit value, two root bits per stage.
module rgt_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [rgt_pkg::RAD_W-1:0]     i_rad,
    output logic                          o_vld,
    output logic [rgt_pkg::ROOT_W-1:0]    o_root
);

    localparam int NSTG  = rgt_pkg::ROOT_STG;
    localparam int BPS   = rgt_pkg::BITS_PER_STG;
    localparam int RAD_W = rgt_pkg::RAD_W;
    localparam int ROOT_W = rgt_pkg::ROOT_W;
    localparam int REM_W = rgt_pkg::REM_W;

    logic               r_vld  [NSTG];
    logic [ROOT_W-1:0]  r_root [NSTG];
    logic [REM_W-1:0]   r_rem  [NSTG];
    logic [RAD_W-1:0]   r_rad  [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic               p_vld;
        logic [ROOT_W-1:0]  p_root, n_root;
        logic [REM_W-1:0]   p_rem,  n_rem;
        logic [RAD_W-1:0]   p_rad,  n_rad;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_root = '0;
            assign p_rem  = '0;
            assign p_rad  = i_rad;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_root = r_root[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_rad  = r_rad[g-1];
        end

        // One restoring step per root bit: bring down two radicand bits and
        // try to subtract 4*root+1.
        always_comb begin
            logic [REM_W-1:0] trial;
            n_root = p_root;
            n_rem  = p_rem;
            n_rad  = p_rad;
            trial  = '0;
            for (int i = 0; i < BPS; i++) begin
                n_rem = {n_rem[REM_W-3:0], n_rad[RAD_W-1:RAD_W-2]};
                n_rad = {n_rad[RAD_W-3:0], 2'b00};
                trial = REM_W'({n_root, 2'b01});
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[g] <= n_root;
            r_rem[g]  <= n_rem;
            r_rad[g]  <= n_rad;
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_root = r_root[NSTG-1];

endmodule

### hw/rtl/rgt_div.sv
`timescale 1ns / 1ps

// Pipelined radius scaling: floor(root * 512 / width), two quotient bits per
// stage. Quotients of 256 or more are flagged instead of computed.
module rgt_div #(
    parameter int DIM_W = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [rgt_pkg::ROOT_W-1:0]    i_root,
    input  logic [DIM_W-1:0]              i_width,
    output logic                          o_vld,
    output logic                          o_over,
    output logic [rgt_pkg::INT_W-1:0]     o_quot
);

    localparam int NSTG  = rgt_pkg::QUOT_STG;
    localparam int BPS   = rgt_pkg::BITS_PER_STG;
    localparam int Q_W   = rgt_pkg::INT_W;
    localparam int N0_W  = rgt_pkg::ROOT_W + rgt_pkg::SCALE_SH;
    localparam int NUM_W = (N0_W > DIM_W + Q_W) ? N0_W : DIM_W + Q_W;

    logic              r_vld  [NSTG];
    logic              r_over [NSTG];
    logic [Q_W-1:0]    r_quot [NSTG];
    logic [NUM_W-1:0]  r_rem  [NSTG];

    logic [NUM_W-1:0]  w_num;
    logic              w_over;

    assign w_num  = NUM_W'({i_root, {rgt_pkg::SCALE_SH{1'b0}}});
    // root*512 >= 256*width exactly when 2*root >= width.
    assign w_over = (NUM_W'({i_root, 1'b0}) >= NUM_W'(i_width));

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic              p_vld, p_over;
        logic [Q_W-1:0]    p_quot, n_quot;
        logic [NUM_W-1:0]  p_rem,  n_rem;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_over = w_over;
            assign p_quot = '0;
            assign p_rem  = w_num;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_over = r_over[g-1];
            assign p_quot = r_quot[g-1];
            assign p_rem  = r_rem[g-1];
        end

        always_comb begin
            logic [NUM_W-1:0] dsub;
            n_quot = p_quot;
            n_rem  = p_rem;
            dsub   = '0;
            for (int i = 0; i < BPS; i++) begin
                dsub = NUM_W'(i_width) << (Q_W - 1 - g * BPS - i);
                if (n_rem >= dsub) begin
                    n_rem  = n_rem - dsub;
                    n_quot = {n_quot[Q_W-2:0], 1'b1};
                end else begin
                    n_quot = {n_quot[Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_over[g] <= p_over;
            r_quot[g] <= n_quot;
            r_rem[g]  <= n_rem;
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_over = r_over[NSTG-1];
    assign o_quot = r_quot[NSTG-1];

endmodule

### hw/rtl/radial_gradient_texture_generator.sv
`timescale 1ns / 1ps

// Radial gradient texture generator. Each word written on start (a pixel
// column and row) yields exactly one 8-bit intensity word on o_intensity,
// marked by o_strobe for a single cycle. The
// block takes a new pixel in every cycle: busy is always low, and the rate of
// one pixel per clock is set by the fully pipelined datapath (three distance
// stages, two four-stage square root units and a four-stage scaling divider).
// The receiver cannot stall the output, so it must take o_intensity in the
// cycle o_strobe is high. Width, height and shape mode are written through
// the plain write port and should only change when no pixel is in flight.
module radial_gradient_texture_generator #(
    parameter int MAX_DIM = rgt_pkg::MAX_DIM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rgt_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [rgt_pkg::PIX_W-1:0]     i_pixel_y,
    input  logic                          i_cfg_we,
    input  logic [rgt_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [rgt_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_strobe,
    output logic [rgt_pkg::INT_W-1:0]     o_intensity
);

    // Clamped dimensions never exceed MAX_DIM nor the 11-bit register range.
    localparam int DIM_RAW = $clog2(MAX_DIM + 1);
    localparam int DIM_W   = (DIM_RAW < rgt_pkg::CFG_W) ? DIM_RAW : rgt_pkg::CFG_W;
    localparam int INT_W   = rgt_pkg::INT_W;
    localparam int RAD_W   = rgt_pkg::RAD_W;
    // Stages of the second square root, across which the cone value is delayed.
    localparam int DLY     = rgt_pkg::ROOT_STG;

    // A zero dimension counts as one, and anything above MAX_DIM saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [rgt_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v[DIM_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers, stored already clamped.
    logic [DIM_W-1:0] r_width, r_height;
    logic             r_shape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_dim(rgt_pkg::CFG_W'(rgt_pkg::RESET_WIDTH));
            r_height <= clamp_dim(rgt_pkg::CFG_W'(rgt_pkg::RESET_HEIGHT));
            r_shape  <= rgt_pkg::SHAPE_CONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgt_pkg::REG_IMAGE_WIDTH:  r_width  <= clamp_dim(i_cfg_wdata);
                rgt_pkg::REG_IMAGE_HEIGHT: r_height <= clamp_dim(i_cfg_wdata);
                rgt_pkg::REG_SHAPE_MODE:   r_shape  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so a word is accepted whenever start is high.
    assign busy = 1'b0;

    // Squared distance from the centre, clamped to 16 bits.
    logic             w_dist_vld;
    logic [RAD_W-1:0] w_dist;

    rgt_dist #(
        .DIM_W (DIM_W)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (start),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_vld     (w_dist_vld),
        .o_dist    (w_dist)
    );

    // Radius as the floor square root of the distance.
    logic                       w_r_vld;
    logic [rgt_pkg::ROOT_W-1:0] w_r;

    rgt_sqrt u_sqrt_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_dist_vld),
        .i_rad   (w_dist),
        .o_vld   (w_r_vld),
        .o_root  (w_r)
    );

    // Radius scaled to the image width; the over flag marks values of 256 up.
    logic             w_s_vld, w_s_over;
    logic [INT_W-1:0] w_s;

    rgt_div #(
        .DIM_W (DIM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_r_vld),
        .i_root  (w_r),
        .i_width (r_width),
        .o_vld   (w_s_vld),
        .o_over  (w_s_over),
        .o_quot  (w_s)
    );

    // Square the scaled radius for the sphere profile. The cone result is
    // already final here and travels alongside the second square root.
    logic             r_sq_vld;
    logic [RAD_W-1:0] r_sq;
    logic             r_over [DLY+1];
    logic [INT_W-1:0] r_cone [DLY+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq      <= w_s * w_s;
        r_over[0] <= w_s_over;
        r_cone[0] <= w_s_over ? '0 : ~w_s;
        for (int i = 1; i <= DLY; i++) begin
            r_over[i] <= r_over[i-1];
            r_cone[i] <= r_cone[i-1];
        end
    end

    // Sphere height: floor square root of 65535 minus the squared radius.
    logic             w_h_vld;
    logic [INT_W-1:0] w_h;

    rgt_sqrt u_sqrt_sphere (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_sq_vld),
        .i_rad   (rgt_pkg::RAD_MAX - r_sq),
        .o_vld   (w_h_vld),
        .o_root  (w_h)
    );

    // Output register: pick the cone or sphere value.
    logic             r_strobe;
    logic [INT_W-1:0] r_intensity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_shape == rgt_pkg::SHAPE_SPHERE) begin
            r_intensity <= r_over[DLY] ? '0 : w_h;
        end else begin
            r_intensity <= r_cone[DLY];
        end
    end

    assign o_strobe    = r_strobe;
    assign o_intensity = r_intensity;

endmodule
